// ===== hw/rtl/nkrs_pkg.sv =====
`timescale 1ns / 1ps

package nkrs_pkg;

    // fixed field widths
    localparam int CMD_W  = 1;
    localparam int REQ_W  = 4;
    localparam int KEY_W  = 10;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 5;
    localparam int CFG_IDX_W = 1;

    // defaults for the top-level parameters
    localparam int MAX_REQUESTERS_DEF = 16;
    localparam int KEY_LIMIT_DEF      = 1000;

    // value both registers take at reset
    localparam int CFG_RESET_VAL = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_IN_USE  = 1'b1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_POST  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_LEAVE = 1'b1;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_POSTED  = 2'd0,
        KIND_REFUSED = 2'd1,
        KIND_LEFT    = 2'd2,
        KIND_SERVED  = 2'd3
    } t_kind;

    // input request
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [REQ_W-1:0] requester;
        logic [KEY_W-1:0] key;
    } t_req;

    // result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REQ_W-1:0]  who;
        logic [KEY_W-1:0]  served_key;
        logic              last;
    } t_rsp;

endpackage

// ===== hw/rtl/nkrs_stream_if.sv =====
`timescale 1ns / 1ps

interface nkrs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/nkrs_ram.sv =====
`timescale 1ns / 1ps

module nkrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/nkrs_scan.sv =====
`timescale 1ns / 1ps

module nkrs_scan #(
    parameter int MAX_REQUESTERS = nkrs_pkg::MAX_REQUESTERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [MAX_REQUESTERS-1:0]         i_valid_bits,
    input  logic signed [nkrs_pkg::KEY_W:0]   i_prev_key,
    output logic                              o_rd_en,
    output logic [$clog2(MAX_REQUESTERS)-1:0] o_rd_addr,
    input  logic [nkrs_pkg::KEY_W-1:0]        i_rd_data,
    output logic                              o_done,
    output logic [$clog2(MAX_REQUESTERS)-1:0] o_best_idx,
    output logic [nkrs_pkg::KEY_W-1:0]        o_best_key
);
    import nkrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_REQUESTERS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REQUESTERS - 1);

    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_chk, n_chk;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic             r_done, n_done;
    logic             r_have, n_have;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    logic [KEY_W-1:0] r_best_key, n_best_key;
    logic [KEY_W:0]   r_best_dist, n_best_dist;

    logic signed [KEY_W+1:0] diff;
    logic [KEY_W:0]          key_gap;
    logic                    better;

    // distance of the entry just read from the previous served key
    always_comb begin
        diff = signed'({2'b00, i_rd_data}) - (KEY_W+2)'(i_prev_key);
        key_gap = diff[KEY_W+1] ? (KEY_W+1)'(-diff) : diff[KEY_W:0];
        better = !r_have || (key_gap < r_best_dist) ||
                 ((key_gap == r_best_dist) && (i_rd_data < r_best_key));
    end

    // address sweep and running best
    always_comb begin
        n_busy      = r_busy;
        n_addr      = r_addr;
        n_chk       = r_busy;
        n_chk_idx   = r_addr;
        n_done      = r_chk && (r_chk_idx == LAST_IDX);
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best_key  = r_best_key;
        n_best_dist = r_best_dist;
        if (i_start) begin
            n_busy = 1'b1;
            n_addr = '0;
            n_have = 1'b0;
        end else if (r_busy) begin
            n_addr = r_addr + 1'b1;
            if (r_addr == LAST_IDX) begin
                n_busy = 1'b0;
            end
        end
        if (r_chk && i_valid_bits[r_chk_idx] && better) begin
            n_have      = 1'b1;
            n_best_idx  = r_chk_idx;
            n_best_key  = i_rd_data;
            n_best_dist = key_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chk  <= 1'b0;
            r_done <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_chk  <= n_chk;
            r_done <= n_done;
            r_have <= n_have;
        end
        r_addr      <= n_addr;
        r_chk_idx   <= n_chk_idx;
        r_best_idx  <= n_best_idx;
        r_best_key  <= n_best_key;
        r_best_dist <= n_best_dist;
    end

    assign o_rd_en    = r_busy;
    assign o_rd_addr  = r_addr;
    assign o_done     = r_done;
    assign o_best_idx = r_best_idx;
    assign o_best_key = r_best_key;
endmodule

// ===== hw/rtl/nearest_key_request_scheduler.sv =====
`timescale 1ns / 1ps

// Nearest-key request scheduler. Each requester holds at most one pending
// request with a key; a post or a leave answers with one result, and when the
// board then holds at least as many requests as the effective limit (and some
// requester is still live) a second result serves the pending request whose
// key lies nearest the last served key, ties to the smaller key and then the
// lower requester index. The last flag marks the final result of a request.
// A request that causes no serve leaves the scheduler idle. One that causes a
// serve blocks the input until the served result is registered: the serve
// sweeps the key memory one entry per cycle through its single read port.
// Keys sit in a memory with no reset; pending and retired flags are
// flip-flops cleared by reset, so there is no clearing pass.
module nearest_key_request_scheduler #(
    parameter int MAX_REQUESTERS = nkrs_pkg::MAX_REQUESTERS_DEF,
    parameter int KEY_LIMIT      = nkrs_pkg::KEY_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nkrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nkrs_pkg::CFG_W-1:0]      i_cfg_data,
    nkrs_stream_if.sink                     i_req,
    nkrs_stream_if.source                   o_rsp
);
    import nkrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_REQUESTERS);
    localparam int CNT_W = $clog2(MAX_REQUESTERS + 1);
    localparam int CMP_W = CNT_W + REQ_W + CFG_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTERS);
    localparam logic [CNT_W-1:0] RST_CNT =
        CNT_W'((MAX_REQUESTERS < CFG_RESET_VAL) ? MAX_REQUESTERS : CFG_RESET_VAL);
    localparam logic [16:0] KEY_LIM_V = 17'(KEY_LIMIT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [MAX_REQUESTERS-1:0] r_valid, n_valid;
    logic [MAX_REQUESTERS-1:0] r_gone, n_gone;
    logic [CNT_W-1:0]          r_pend, n_pend;
    logic [CNT_W-1:0]          r_live, n_live;
    logic [CNT_W-1:0]          r_eff, n_eff;
    logic [CNT_W-1:0]          r_users, n_users;
    logic signed [KEY_W:0]     r_prev, n_prev;
    logic                      r_out_valid, n_out_valid;
    t_rsp                      r_out, n_out;

    t_req             req;
    logic [IDX_W-1:0] req_idx;
    logic             accept, out_free;
    logic             exists, post_ok, leave_ok, serve;
    logic [CNT_W-1:0] live_dec, cfg_clamp_users, cfg_clamp_limit;

    logic             scan_start, scan_done, rd_en;
    logic [IDX_W-1:0] rd_addr, best_idx;
    logic [KEY_W-1:0] rd_data, best_key;

    assign req      = i_req.payload;
    assign req_idx  = IDX_W'(req.requester);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign accept   = i_req.valid && i_req.ready;

    assign i_req.ready   = (r_state == ST_IDLE) && out_free;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // admission checks on the incoming request
    always_comb begin
        exists   = CMP_W'(req.requester) < CMP_W'(r_users);
        leave_ok = exists && !r_gone[req_idx] && !r_valid[req_idx];
        post_ok  = leave_ok && (r_pend < r_eff) && (17'(req.key) < KEY_LIM_V);
        live_dec = (r_live != '0) ? r_live - 1'b1 : r_live;
    end

    // clamped configuration values
    always_comb begin
        cfg_clamp_users = (CMP_W'(i_cfg_data) > CMP_W'(MAX_CNT)) ? MAX_CNT
                                                                : CNT_W'(i_cfg_data);
        cfg_clamp_limit = (i_cfg_data == '0) ? CNT_W'(1) : cfg_clamp_users;
    end

    // next state of the board and the sequencer
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_gone      = r_gone;
        n_pend      = r_pend;
        n_live      = r_live;
        n_eff       = r_eff;
        n_users     = r_users;
        n_prev      = r_prev;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        scan_start  = 1'b0;
        serve       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out.who        = req.requester;
                    n_out.served_key = '0;
                    n_out.kind       = KIND_REFUSED;
                    if (req.command == CMD_POST) begin
                        if (post_ok) begin
                            n_valid[req_idx] = 1'b1;
                            n_pend           = r_pend + 1'b1;
                            n_out.kind       = KIND_POSTED;
                            n_out.served_key = req.key;
                        end
                    end else if (leave_ok) begin
                        n_gone[req_idx] = 1'b1;
                        n_live          = live_dec;
                        n_eff           = (live_dec < r_eff) ? live_dec : r_eff;
                        n_out.kind      = KIND_LEFT;
                    end
                    serve       = (n_live != '0) && (n_pend != '0) && (n_pend >= n_eff);
                    n_out.last  = !serve;
                    n_out_valid = 1'b1;
                    if (serve) begin
                        scan_start = 1'b1;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_SCAN, ST_EMIT: begin
                if (scan_done || r_state == ST_EMIT) begin
                    if (out_free) begin
                        n_valid[best_idx] = 1'b0;
                        n_pend            = r_pend - 1'b1;
                        n_prev            = signed'({1'b0, best_key});
                        n_out.kind        = KIND_SERVED;
                        n_out.who         = REQ_W'(best_idx);
                        n_out.served_key  = best_key;
                        n_out.last        = 1'b1;
                        n_out_valid       = 1'b1;
                        n_state           = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // register writes: the user must write only while idle; the block does not enforce it
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOARD_LIMIT: n_eff = cfg_clamp_limit;
                CFG_REQ_IN_USE: begin
                    n_users = cfg_clamp_users;
                    n_live  = cfg_clamp_users;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_gone      <= '0;
            r_pend      <= '0;
            r_live      <= RST_CNT;
            r_eff       <= RST_CNT;
            r_users     <= RST_CNT;
            r_prev      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_gone      <= n_gone;
            r_pend      <= n_pend;
            r_live      <= n_live;
            r_eff       <= n_eff;
            r_users     <= n_users;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // key store, written on an admitted post
    nkrs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_REQUESTERS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (req.command == CMD_POST) && post_ok),
        .i_waddr (req_idx),
        .i_wdata (req.key),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // nearest-key sweep over the key store
    nkrs_scan #(
        .MAX_REQUESTERS (MAX_REQUESTERS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (scan_start),
        .i_valid_bits (r_valid),
        .i_prev_key   (r_prev),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_done       (scan_done),
        .o_best_idx   (best_idx),
        .o_best_key   (best_key)
    );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import nkrs_pkg::*;

    localparam int SLOTS         = MAX_REQUESTERS_DEF;
    localparam int KEY_CAP       = KEY_LIMIT_DEF;
    localparam int SETTLE_CYCLES = SLOTS + 3 + 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRINT_CAP     = 60;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;
    typedef enum int {ROW_REQ, ROW_LIMIT, ROW_USERS} t_row_kind;

    // first result of a request as typed into the directed plan
    typedef struct {
        bit               on;
        t_kind            kind;
        logic [KEY_W-1:0] key;
    } t_answer;

    typedef struct {
        t_row_kind        row_kind;
        logic [CFG_W-1:0] value;
        logic [CMD_W-1:0] command;
        logic [REQ_W-1:0] requester;
        logic [KEY_W-1:0] key;
        t_answer          answer;
    } t_row;

    typedef struct {
        int    limit;
        int    users;
        t_idle mode;
        int    items;
        bit    hold;
    } t_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    nkrs_stream_if #(.t_payload(t_req)) req_if ();
    nkrs_stream_if #(.t_payload(t_rsp)) rsp_if ();

    nearest_key_request_scheduler DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_if.sink),
        .o_rsp     (rsp_if.source)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the board
    logic [CFG_W-1:0] limit_reg = CFG_W'(CFG_RESET_VAL);
    logic [CFG_W-1:0] users_reg = CFG_W'(CFG_RESET_VAL);
    bit               slot_on [SLOTS];
    logic [KEY_W-1:0] slot_k [SLOTS];
    bit               retired [SLOTS];
    int               board_count = 0;
    int               live_left = SLOTS;
    int               cur_limit = SLOTS;
    int               last_served = -1;

    t_rsp    awaited_rsp[$];
    t_row    directed_plan[$];
    t_phase  phases[$];
    t_answer row_answer;
    t_idle   idle_mode = IDLE_NONE;
    int      hold_asks = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    function automatic int limit_of(logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        return (v > SLOTS) ? SLOTS : int'(v);
    endfunction

    function automatic int users_of(logic [CFG_W-1:0] v);
        return (v > SLOTS) ? SLOTS : int'(v);
    endfunction

    function automatic int stall_pct(bit receiver_side);
        case (idle_mode)
            IDLE_SEND: return receiver_side ? 0 : 84;
            IDLE_RECV: return receiver_side ? 84 : 0;
            IDLE_BOTH: return 13;
            default: return 0;
        endcase
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        if (idx == CFG_BOARD_LIMIT) begin
            limit_reg = v;
            cur_limit = limit_of(v);
        end else begin
            users_reg = v;
            live_left = users_of(v);
        end
    endfunction

    // answer the request, then serve the nearest key if the board is at its limit
    function automatic void book_request(t_req r, t_answer ans);
        t_rsp first;
        t_rsp served;
        int   pick;
        int   best_d;
        int   d;
        bit   known;
        first.kind       = KIND_REFUSED;
        first.who        = r.requester;
        first.served_key = '0;
        first.last       = 1'b1;
        known = int'(r.requester) < users_of(users_reg);
        if (r.command == CMD_POST) begin
            if (known && !retired[r.requester] && !slot_on[r.requester] &&
                    board_count < cur_limit && r.key < KEY_CAP) begin
                slot_on[r.requester] = 1'b1;
                slot_k[r.requester]  = r.key;
                board_count++;
                first.kind       = KIND_POSTED;
                first.served_key = r.key;
            end
        end else if (known && !retired[r.requester] && !slot_on[r.requester]) begin
            retired[r.requester] = 1'b1;
            if (live_left > 0) live_left--;
            if (live_left < cur_limit) cur_limit = live_left;
            first.kind = KIND_LEFT;
        end
        if (ans.on) begin
            first.kind       = ans.kind;
            first.served_key = ans.key;
        end

        pick   = -1;
        best_d = 0;
        if (live_left > 0 && board_count > 0 && board_count >= cur_limit) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_on[i]) begin
                    d = int'(slot_k[i]) - last_served;
                    if (d < 0) d = -d;
                    if (pick < 0 || d < best_d || (d == best_d && slot_k[i] < slot_k[pick])) begin
                        pick   = i;
                        best_d = d;
                    end
                end
            end
        end
        awaited_rsp.push_back(first);
        if (pick >= 0) begin
            awaited_rsp[awaited_rsp.size()-1].last = 1'b0;
            served.kind       = KIND_SERVED;
            served.who        = REQ_W'(pick);
            served.served_key = slot_k[pick];
            served.last       = 1'b1;
            slot_on[pick] = 1'b0;
            board_count--;
            last_served = int'(slot_k[pick]);
            awaited_rsp.push_back(served);
        end
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= PRINT_CAP) $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_result(t_rsp got);
        t_rsp want;
        if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected result: kind %0d who %0d key %0d last %0d",
                got.kind, got.who, got.served_key, got.last));
            return;
        end
        want = awaited_rsp.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind: got %0d want %0d (who %0d)",
                got.kind, want.kind, want.who));
        if (got.who !== want.who)
            report_mismatch($sformatf("who: got %0d want %0d", got.who, want.who));
        if (got.served_key !== want.served_key)
            report_mismatch($sformatf("served_key: got %0d want %0d (who %0d)",
                got.served_key, want.served_key, want.who));
        if (got.last !== want.last)
            report_mismatch($sformatf("last: got %0d want %0d (who %0d)",
                got.last, want.last, want.who));
    endtask

    // sample writes, accepted requests and results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) apply_config(i_cfg_idx, i_cfg_data);
            if (req_if.valid && req_if.ready) book_request(req_if.payload, row_answer);
            if (rsp_if.valid && rsp_if.ready) check_result(rsp_if.payload);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result sink: random stalls plus an occasional long hold-off
    initial begin : rsp_sink
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_asks) begin
                holds_done = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct(1'b1));
            end
        end
    end

    task automatic send_request(t_req r, t_answer ans);
        while ($urandom_range(99) < stall_pct(1'b0)) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        row_answer     <= ans;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained(int extra);
        req_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        wait_drained(SETTLE_CYCLES);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_row ask(logic [CMD_W-1:0] cmd, int who, int key,
                                 bit typed = 1'b0, t_kind kind = KIND_POSTED, int k = 0);
        t_row row;
        row.row_kind    = ROW_REQ;
        row.value       = '0;
        row.command     = cmd;
        row.requester   = REQ_W'(who);
        row.key         = KEY_W'(key);
        row.answer.on   = typed;
        row.answer.kind = kind;
        row.answer.key  = KEY_W'(k);
        return row;
    endfunction

    function automatic t_row set_reg(t_row_kind which, int v);
        t_row row;
        row = ask(CMD_POST, 0, 0);
        row.row_kind = which;
        row.value    = CFG_W'(v);
        return row;
    endfunction

    function automatic t_phase phase(int limit, int users, t_idle mode, int items, bit hold);
        t_phase ph;
        ph.limit = limit;
        ph.users = users;
        ph.mode  = mode;
        ph.items = items;
        ph.hold  = hold;
        return ph;
    endfunction

    // mostly well-formed posts with random keys, some leaves and bad posts
    function automatic t_req random_request(bit leaves_ok);
        t_req r;
        int   roll;
        int   start;
        int   cand;
        roll        = $urandom_range(99);
        r.command   = CMD_POST;
        r.requester = REQ_W'($urandom_range(SLOTS-1));
        r.key       = KEY_W'($urandom_range(KEY_CAP-1));
        if (roll < 72) begin
            // a requester that can take a new request
            start = $urandom_range(SLOTS-1);
            for (int n = 0; n < SLOTS; n++) begin
                cand = (start + n) % SLOTS;
                if (cand < users_of(users_reg) && !retired[cand] && !slot_on[cand]) begin
                    r.requester = REQ_W'(cand);
                    break;
                end
            end
            roll = $urandom_range(99);
            if (roll < 20) begin
                // same key as a pending request, for ties
                start = $urandom_range(SLOTS-1);
                for (int n = 0; n < SLOTS; n++) begin
                    cand = (start + n) % SLOTS;
                    if (slot_on[cand]) begin
                        r.key = slot_k[cand];
                        break;
                    end
                end
            end else if (roll < 40) begin
                cand  = last_served + int'($urandom_range(6)) - 3;
                r.key = KEY_W'(cand < 0 ? 0 : (cand > KEY_CAP-1 ? KEY_CAP-1 : cand));
            end else if (roll < 48) begin
                r.key = ($urandom_range(1) != 0) ? KEY_W'(KEY_CAP-1) : '0;
            end
        end else if (roll < 86) begin
            r.command = CMD_LEAVE;
            r.key     = KEY_W'($urandom_range(1023));
            // keep the requester pool alive until the last phase
            if (!leaves_ok && int'(r.requester) < users_of(users_reg) &&
                    !retired[r.requester] && !slot_on[r.requester] &&
                    $urandom_range(99) >= 3)
                r.command = CMD_POST;
        end else if (roll < 94) begin
            r.key = KEY_W'($urandom_range(1023, KEY_CAP));
        end
        return r;
    endfunction

    initial begin
        t_row    row;
        t_req    r;
        t_answer no_answer;
        t_phase  ph;
        no_answer.on   = 1'b0;
        no_answer.kind = KIND_POSTED;
        no_answer.key  = '0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        row_answer     = no_answer;
        foreach (slot_on[i]) begin
            slot_on[i] = 1'b0;
            slot_k[i]  = '0;
            retired[i] = 1'b0;
        end

        // directed plan
        directed_plan.push_back(set_reg(ROW_LIMIT, 3));
        directed_plan.push_back(set_reg(ROW_USERS, 5));
        directed_plan.push_back(ask(CMD_POST, 0, 999, 1'b1, KIND_POSTED, 999));
        // out-of-range keys, repeat post, missing requesters
        directed_plan.push_back(ask(CMD_POST, 1, 1023, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 1, 1000, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 0, 5, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 5, 7, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 15, 0, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 2, 0, 1'b1, KIND_POSTED, 0));
        // board reaches its limit with two equal keys
        directed_plan.push_back(ask(CMD_POST, 1, 0));
        directed_plan.push_back(ask(CMD_LEAVE, 1, 0));
        // leave twice, post after leaving, leave with a pending request
        directed_plan.push_back(ask(CMD_LEAVE, 1, 0, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 1, 3, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_LEAVE, 0, 1023, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_LEAVE, 7, 0, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 3, 512));
        // limit lowered under the board count: a serve after each request until the board is empty
        directed_plan.push_back(set_reg(ROW_LIMIT, 1));
        directed_plan.push_back(ask(CMD_LEAVE, 15, 0, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 4, 512, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 4, 512));
        directed_plan.push_back(ask(CMD_LEAVE, 4, 0, 1'b1, KIND_LEFT));
        // no live requesters left: pending requests stay put until the pool is restored
        directed_plan.push_back(set_reg(ROW_LIMIT, 16));
        directed_plan.push_back(ask(CMD_POST, 3, 200, 1'b1, KIND_POSTED, 200));
        directed_plan.push_back(ask(CMD_POST, 2, 300, 1'b1, KIND_POSTED, 300));
        directed_plan.push_back(set_reg(ROW_USERS, 1));
        directed_plan.push_back(ask(CMD_LEAVE, 0, 0, 1'b1, KIND_LEFT));
        directed_plan.push_back(ask(CMD_POST, 0, 1, 1'b1, KIND_REFUSED));
        directed_plan.push_back(ask(CMD_POST, 2, 1, 1'b1, KIND_REFUSED));
        directed_plan.push_back(set_reg(ROW_LIMIT, 1));
        directed_plan.push_back(ask(CMD_LEAVE, 3, 0, 1'b1, KIND_REFUSED));
        directed_plan.push_back(set_reg(ROW_USERS, 16));
        directed_plan.push_back(ask(CMD_POST, 5, 250));

        // random phases: limit, users, idling, request count, long hold-off
        phases.push_back(phase(16, 16, IDLE_NONE, 160, 1'b0));
        phases.push_back(phase(1, 16, IDLE_SEND, 160, 1'b0));
        phases.push_back(phase(5, 16, IDLE_RECV, 160, 1'b0));
        phases.push_back(phase(0, 31, IDLE_BOTH, 160, 1'b0));
        phases.push_back(phase(31, 17, IDLE_NONE, 160, 1'b1));
        phases.push_back(phase(3, 8, IDLE_SEND, 150, 1'b0));
        phases.push_back(phase(8, 16, IDLE_RECV, 150, 1'b0));
        phases.push_back(phase(2, 0, IDLE_BOTH, 40, 1'b0));
        phases.push_back(phase(12, 16, IDLE_NONE, 160, 1'b0));
        phases.push_back(phase($urandom_range(31), $urandom_range(31), IDLE_SEND, 150, 1'b0));
        phases.push_back(phase(4, 16, IDLE_BOTH, 160, 1'b0));
        phases.push_back(phase(6, 16, IDLE_RECV, 160, 1'b0));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            case (row.row_kind)
                ROW_LIMIT: write_reg(CFG_BOARD_LIMIT, row.value);
                ROW_USERS: write_reg(CFG_REQ_IN_USE, row.value);
                default: begin
                    r.command   = row.command;
                    r.requester = row.requester;
                    r.key       = row.key;
                    send_request(r, row.answer);
                end
            endcase
        end

        // random part, leaves succeed freely only in the last phase
        foreach (phases[p]) begin
            ph = phases[p];
            write_reg(CFG_BOARD_LIMIT, CFG_W'(ph.limit));
            write_reg(CFG_REQ_IN_USE, CFG_W'(ph.users));
            idle_mode = ph.mode;
            if (ph.hold) hold_asks++;
            repeat (ph.items) begin
                send_request(random_request(p == phases.size() - 1), no_answer);
            end
        end

        wait_drained(SETTLE_CYCLES);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/nkrs_pkg.sv
hw/rtl/nkrs_stream_if.sv
hw/rtl/nkrs_ram.sv
hw/rtl/nkrs_scan.sv
hw/rtl/nearest_key_request_scheduler.sv
tb/testbench.sv
